FILE: sv/windowed_event_code_counter_macros.svh
// Assertion macros for the windowed event code counter.
// Both macros expect signals named clk and rst in the scope that uses them.
`ifndef WINDOWED_EVENT_CODE_COUNTER_MACROS_SVH
`define WINDOWED_EVENT_CODE_COUNTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define WECC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wecc: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define WECC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wecc: next-cycle check failed");

`endif

FILE: sv/wecc_pkg.sv
// Shared types, sizes and helper functions of the windowed event code counter.
// No dependencies; the design modules and the testbench import this package.
package wecc_pkg;

  localparam int RING_DEPTH  = 1024;
  localparam int PTR_W       = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int FILL_W      = $clog2(RING_DEPTH + 1);
  localparam int COUNT_W     = 11;
  localparam int TIME_W      = 31;
  localparam int CODE_W      = 16;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int CFG_INDEX_W = 1;

  localparam logic [CODE_W-1:0] SPIKE_LOW_RESET  = 16'd600;
  localparam logic [CODE_W-1:0] SPIKE_HIGH_RESET = 16'd700;

  // Input opcode values.
  localparam logic OPC_APPEND = 1'b0;
  localparam logic OPC_QUERY  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_SPIKE_LOW  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPIKE_HIGH = 1'd1;

  typedef logic [PTR_W-1:0] ptr_t;

  typedef enum logic [0:0] {
    OP_APPEND = 1'b0,
    OP_QUERY  = 1'b1
  } op_t;

  // One classified request as it travels from the front to the back.
  // arg carries the event time of an append or the window of a query;
  // code carries the event code of an append or the match code of a query.
  typedef struct packed {
    op_t                     op;
    logic                    any;
    logic [TIME_W-1:0]       arg;
    logic signed [CODE_W-1:0] code;
  } cmd_t;

  typedef struct packed {
    logic idle;
    logic walking;
    logic delivering;
  } back_stat_t;

  function automatic ptr_t step_back(ptr_t i);
    return (i == '0) ? ptr_t'(RING_DEPTH - 1) : ptr_t'(i - 1'b1);
  endfunction

  function automatic ptr_t step_fwd(ptr_t i);
    return (i == ptr_t'(RING_DEPTH - 1)) ? '0 : ptr_t'(i + 1'b1);
  endfunction

endpackage

FILE: sv/wecc_front.sv
// Front end: accepts input requests, classifies them and holds them in a short queue.
// Depends on wecc_pkg.
module wecc_front (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic [wecc_pkg::TIME_W-1:0]          event_time,
  input  logic signed [wecc_pkg::CODE_W-1:0]   event_code,
  input  logic [wecc_pkg::TIME_W-1:0]          window_length,
  input  logic                                 match_any,
  input  logic signed [wecc_pkg::CODE_W-1:0]   match_code,
  output logic                                 cmd_valid,
  output wecc_pkg::cmd_t                       cmd,
  input  logic                                 cmd_pop
);
  import wecc_pkg::*;

  cmd_t              queue [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  cmd_t              cls;
  logic              push;
  logic              is_query;

  always_comb begin
    is_query = (opcode == OPC_QUERY);
    cls.op   = is_query ? OP_QUERY : OP_APPEND;
    cls.any  = is_query & match_any;
    cls.arg  = is_query ? window_length : event_time;
    cls.code = is_query ? match_code : event_code;
  end

  assign in_stall  = (fill == QCNT_W'(QUEUE_DEPTH));
  assign push      = in_valid && !in_stall;
  assign cmd_valid = (fill != '0);
  assign cmd       = queue[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      queue[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(wr_ptr + 1'b1);
      end
      if (cmd_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : QPTR_W'(rd_ptr + 1'b1);
      end
      case ({push, cmd_pop})
        2'b10:   fill <= QCNT_W'(fill + 1'b1);
        2'b01:   fill <= QCNT_W'(fill - 1'b1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

FILE: sv/wecc_back.sv
// Back end: owns the event ring, performs appends and walks it for count queries.
// Depends on wecc_pkg; results leave through a registered output.
module wecc_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cmd_valid,
  input  wecc_pkg::cmd_t                       cmd,
  output logic                                 cmd_pop,
  input  logic signed [wecc_pkg::CODE_W-1:0]   spike_code_low,
  input  logic signed [wecc_pkg::CODE_W-1:0]   spike_code_high,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wecc_pkg::COUNT_W-1:0]         spike_count,
  output wecc_pkg::back_stat_t                 stat
);
  import wecc_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_FIRST   = 4'b0010,
    S_WALK    = 4'b0100,
    S_DELIVER = 4'b1000
  } state_t;

  state_t                   state;
  state_t                   state_next;

  logic [TIME_W-1:0]        ring_time [RING_DEPTH];
  logic [CODE_W-1:0]        ring_code [RING_DEPTH];

  ptr_t                     write_index;
  logic [FILL_W-1:0]        fill;
  ptr_t                     walk_addr;
  ptr_t                     rd_addr;
  logic [TIME_W-1:0]        rd_time;
  logic [CODE_W-1:0]        rd_code;
  logic                     rd_ok;

  logic                     q_any;
  logic signed [CODE_W-1:0] q_code;
  logic [TIME_W-1:0]        q_window;
  logic [TIME_W-1:0]        newest;
  logic signed [TIME_W:0]   start;
  logic [COUNT_W-1:0]       count;

  logic [TIME_W-1:0]        eff_time;
  logic signed [CODE_W-1:0] eff_code;
  logic signed [TIME_W:0]   eff_time_s;
  logic signed [TIME_W:0]   start_calc;
  logic                     hit;
  logic                     stop;
  logic                     do_append;
  logic                     out_free;

  // Entries that were never written read as zero: the ring fills in order, so
  // a fill count tells which ones hold data.
  assign eff_time   = rd_ok ? rd_time : '0;
  assign eff_code   = rd_ok ? $signed(rd_code) : '0;
  assign eff_time_s = $signed({1'b0, eff_time});
  assign start_calc = eff_time_s - $signed({1'b0, q_window});

  assign hit = q_any ? ((eff_code > spike_code_low) && (eff_code < spike_code_high))
                     : (eff_code == q_code);

  assign stop = (eff_time == newest) || (eff_time == '0) || !(eff_time_s > start);

  assign cmd_pop   = (state == S_IDLE) && cmd_valid;
  assign do_append = cmd_pop && (cmd.op == OP_APPEND);
  assign out_free  = !out_valid || !out_stall;

  assign rd_addr = (state == S_IDLE) ? step_back(write_index) : walk_addr;

  always_ff @(posedge clk) begin
    if (do_append) begin
      ring_time[write_index] <= cmd.arg;
      ring_code[write_index] <= cmd.code;
    end
  end

  always_ff @(posedge clk) begin
    rd_time <= ring_time[rd_addr];
    rd_code <= ring_code[rd_addr];
    rd_ok   <= (FILL_W'(rd_addr) < fill);
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (cmd_pop && (cmd.op == OP_QUERY)) begin
          state_next = S_FIRST;
        end
      end
      S_FIRST: begin
        // The newest entry only lies inside a window of nonzero length.
        state_next = (q_window != '0) ? S_WALK : S_DELIVER;
      end
      S_WALK: begin
        if (stop) begin
          state_next = S_DELIVER;
        end
      end
      S_DELIVER: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      write_index <= '0;
      fill        <= '0;
      out_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (do_append) begin
        write_index <= step_fwd(write_index);
        if (fill != FILL_W'(RING_DEPTH)) begin
          fill <= FILL_W'(fill + 1'b1);
        end
      end
      if (state == S_DELIVER && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (cmd_pop) begin
          q_any     <= cmd.any;
          q_code    <= cmd.code;
          q_window  <= cmd.arg;
          walk_addr <= step_back(step_back(write_index));
        end
      end
      S_FIRST: begin
        newest    <= eff_time;
        start     <= start_calc;
        count     <= (q_window != '0) ? COUNT_W'(hit) : '0;
        walk_addr <= step_back(walk_addr);
      end
      S_WALK: begin
        if (!stop) begin
          count <= COUNT_W'(count + COUNT_W'(hit));
        end
        walk_addr <= step_back(walk_addr);
      end
      S_DELIVER: begin
        if (out_free) begin
          spike_count <= count;
        end
      end
      default: begin
      end
    endcase
  end

  assign stat.idle       = (state == S_IDLE);
  assign stat.walking    = (state == S_FIRST) || (state == S_WALK);
  assign stat.delivering = (state == S_DELIVER);

endmodule

FILE: sv/windowed_event_code_counter.sv
// Windowed event code counter. Appends write a timestamped code into a ring of
// RING_DEPTH entries, and a stream of appends runs at one per cycle. A count
// query walks back from the newest entry through the ring's single read port,
// one entry per cycle: it occupies the back end while it reads the entries after
// the newest one (at most RING_DEPTH, when the walk wraps all the way round to
// the newest entry) and while its result waits on out_stall. New requests wait
// in the two-entry input queue meanwhile. The ring is treated as all zero after
// reset through a fill count, so there is no clearing pass. Configuration writes
// take effect at once and should only be issued while no request is in flight.
module windowed_event_code_counter (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [wecc_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [wecc_pkg::CODE_W-1:0]          cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 opcode,
  input  logic [wecc_pkg::TIME_W-1:0]          event_time,
  input  logic signed [wecc_pkg::CODE_W-1:0]   event_code,
  input  logic [wecc_pkg::TIME_W-1:0]          window_length,
  input  logic                                 match_any,
  input  logic signed [wecc_pkg::CODE_W-1:0]   match_code,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [wecc_pkg::COUNT_W-1:0]         spike_count
);
  import wecc_pkg::*;

  `include "windowed_event_code_counter_macros.svh"

  logic signed [CODE_W-1:0] spike_code_low;
  logic signed [CODE_W-1:0] spike_code_high;
  logic                     cmd_valid;
  cmd_t                     cmd;
  logic                     cmd_pop;
  back_stat_t               stat;

  always_ff @(posedge clk) begin
    if (rst) begin
      spike_code_low  <= $signed(SPIKE_LOW_RESET);
      spike_code_high <= $signed(SPIKE_HIGH_RESET);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SPIKE_LOW:  spike_code_low  <= $signed(cfg_data);
        REG_SPIKE_HIGH: spike_code_high <= $signed(cfg_data);
        default: begin
        end
      endcase
    end
  end

  wecc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .opcode        (opcode),
    .event_time    (event_time),
    .event_code    (event_code),
    .window_length (window_length),
    .match_any     (match_any),
    .match_code    (match_code),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  wecc_back u_back (
    .clk             (clk),
    .rst             (rst),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop),
    .spike_code_low  (spike_code_low),
    .spike_code_high (spike_code_high),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .spike_count     (spike_count),
    .stat            (stat)
  );

  // A request is only taken from the queue when one is waiting.
  `WECC_ASSERT_NOW(a_pop_needs_request, cmd_pop, cmd_valid)
  // Nothing leaves the queue while a query walks the ring.
  `WECC_ASSERT_NOW(a_no_pop_while_walking, stat.walking, !cmd_pop)
  // A finished query whose result slot is free shows its result next cycle.
  `WECC_ASSERT_NEXT(a_result_follows_delivery, stat.delivering && !(out_valid && out_stall),
                    out_valid)

endmodule

FILE: tb/sv/windowed_event_code_counter_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for the windowed event code counter.
// Depends on wecc_pkg and windowed_event_code_counter; predicts every count query
// from its own copy of the event ring and spike range registers.
module windowed_event_code_counter_tb;
  import wecc_pkg::*;

  localparam int SETTLE_CYCLES = 16;
  localparam int CYCLE_LIMIT   = 8_000_000;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                     cfg_we = 1'b0;
  logic [CFG_INDEX_W-1:0]   cfg_index = REG_SPIKE_LOW;
  logic [CODE_W-1:0]        cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic                     opcode = OPC_APPEND;
  logic [TIME_W-1:0]        event_time = '0;
  logic signed [CODE_W-1:0] event_code = '0;
  logic [TIME_W-1:0]        window_length = '0;
  logic                     match_any = 1'b0;
  logic signed [CODE_W-1:0] match_code = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [COUNT_W-1:0]       spike_count;

  windowed_event_code_counter DUT (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .opcode(opcode),
    .event_time(event_time),
    .event_code(event_code),
    .window_length(window_length),
    .match_any(match_any),
    .match_code(match_code),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .spike_count(spike_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predicted state of the block.
  logic [TIME_W-1:0]        ring_times [RING_DEPTH];
  logic signed [CODE_W-1:0] ring_codes [RING_DEPTH];
  int unsigned              ring_wr_ptr = 0;
  logic signed [CODE_W-1:0] spike_lo = SPIKE_LOW_RESET;
  logic signed [CODE_W-1:0] spike_hi = SPIKE_HIGH_RESET;

  logic [COUNT_W-1:0] expected_counts [$];
  int                 error_count = 0;
  logic               idling_on = 1'b1;
  logic [TIME_W-1:0]  stamp_now = '0;
  int                 cycle_count = 0;

  // Walks back from the newest event, counting matches while the event time lies
  // after the window start. The window start is signed and may be negative.
  function automatic logic [COUNT_W-1:0] count_in_window(logic [TIME_W-1:0] win,
      logic any, logic signed [CODE_W-1:0] want);
    int unsigned              p;
    longint                   newest;
    longint                   start_time;
    int unsigned              hits;
    int unsigned              steps;
    logic signed [CODE_W-1:0] c;
    logic                     hit;
    p = (ring_wr_ptr + RING_DEPTH - 1) % RING_DEPTH;
    newest = longint'(ring_times[p]);
    start_time = newest - longint'(win);
    hits = 0;
    steps = 0;
    while (longint'(ring_times[p]) > start_time && steps < RING_DEPTH) begin
      c = ring_codes[p];
      hit = any ? (c > spike_lo && c < spike_hi) : (c == want);
      if (hit) hits++;
      steps++;
      p = (p + RING_DEPTH - 1) % RING_DEPTH;
      if (longint'(ring_times[p]) == newest || ring_times[p] == '0) break;
    end
    return hits[COUNT_W-1:0];
  endfunction

  function automatic logic signed [CODE_W-1:0] pick_code();
    case ($urandom_range(0, 5))
      0: return CODE_W'(int'(spike_lo) + $urandom_range(0, 2) - 1);
      1: return CODE_W'(int'(spike_hi) + $urandom_range(0, 2) - 1);
      2: return CODE_W'($urandom_range(0, 3));
      3: return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
      4: return CODE_W'($urandom_range(600, 700));
      default: return CODE_W'($urandom);
    endcase
  endfunction

  task automatic report_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // Drives one request and waits for its acceptance; the predictor is updated
  // at the accepting edge.
  task automatic send_request(input logic op, input logic [TIME_W-1:0] t,
      input logic signed [CODE_W-1:0] code, input logic [TIME_W-1:0] win,
      input logic any, input logic signed [CODE_W-1:0] want);
    if (idling_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    event_time <= t;
    event_code <= code;
    window_length <= win;
    match_any <= any;
    match_code <= want;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (op == OPC_QUERY) begin
      expected_counts.push_back(count_in_window(win, any, want));
    end else begin
      ring_times[ring_wr_ptr] = t;
      ring_codes[ring_wr_ptr] = code;
      ring_wr_ptr = (ring_wr_ptr + 1) % RING_DEPTH;
    end
  endtask

  task automatic append_event(input logic [TIME_W-1:0] t,
      input logic signed [CODE_W-1:0] code);
    send_request(OPC_APPEND, t, code, TIME_W'($urandom), 1'($urandom_range(0, 1)),
                 CODE_W'($urandom));
  endtask

  task automatic query_count(input logic [TIME_W-1:0] win, input logic any,
      input logic signed [CODE_W-1:0] want);
    send_request(OPC_QUERY, TIME_W'($urandom), CODE_W'($urandom), win, any, want);
  endtask

  // Holds off new requests until every pending count has come back and any
  // trailing appends have drained.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_spike_range(input logic signed [CODE_W-1:0] lo,
      input logic signed [CODE_W-1:0] hi);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_SPIKE_LOW;
    cfg_data <= lo;
    @(posedge clk);
    cfg_index <= REG_SPIKE_HIGH;
    cfg_data <= hi;
    @(posedge clk);
    cfg_we <= 1'b0;
    spike_lo = lo;
    spike_hi = hi;
  endtask

  // Mostly time-ordered appends with occasional queries, plus some zero-time,
  // random and out-of-order appends.
  task automatic run_traffic(input int n_items, input int query_pct);
    logic [TIME_W-1:0] win;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 99) < query_pct) begin
        case ($urandom_range(0, 5))
          0: win = '0;
          1: win = TIME_W'($urandom_range(1, 64));
          2: win = TIME_W'($urandom_range(65, 20000));
          3: win = '1;
          default: win = TIME_W'($urandom);
        endcase
        query_count(win, 1'($urandom_range(0, 1)), pick_code());
      end else if ($urandom_range(0, 9) == 0) begin
        case ($urandom_range(0, 2))
          0: append_event('0, pick_code());
          1: append_event(TIME_W'($urandom), CODE_W'($urandom));
          default: append_event(stamp_now - TIME_W'($urandom_range(0, 500)), pick_code());
        endcase
      end else begin
        stamp_now = stamp_now + TIME_W'($urandom_range(0, 40));
        append_event(stamp_now, pick_code());
      end
    end
  endtask

  task automatic test_empty_ring();
    query_count('0, 1'b0, '0);
    query_count(TIME_W'(5), 1'b0, '0);
    query_count('1, 1'b1, '0);
    query_count(TIME_W'(1), 1'b0, 16'sh8000);
  endtask

  task automatic test_range_registers();
    set_spike_range(16'sh8000, 16'sh7FFF);
    query_count(TIME_W'(1), 1'b1, '0);
    set_spike_range(-16'sd1, 16'sd1);
    query_count(TIME_W'(1), 1'b1, '0);
    set_spike_range(16'sd0, 16'sd1);
    query_count(TIME_W'(1), 1'b1, '0);
  endtask

  task automatic test_code_extremes();
    append_event(TIME_W'(100), 16'sh8000);
    append_event('1, 16'sh7FFF);
    query_count('1, 1'b0, 16'sh7FFF);
    query_count('1, 1'b0, 16'sh8000);
    query_count('1, 1'b1, 16'sh7FFF);
  endtask

  // A zero timestamp ends the walk, and so does an older entry that repeats
  // the newest time.
  task automatic test_walk_stops();
    append_event('0, '0);
    append_event(TIME_W'(500), 16'sd7);
    append_event(TIME_W'(500), 16'sd7);
    append_event(TIME_W'(600), 16'sd7);
    query_count(TIME_W'(1000), 1'b0, 16'sd7);
    append_event(TIME_W'(600), 16'sd7);
    query_count(TIME_W'(1000), 1'b0, 16'sd7);
    query_count('0, 1'b0, 16'sd7);
    query_count(TIME_W'(100), 1'b0, 16'sd7);
  endtask

  task automatic test_mixed_traffic();
    set_spike_range(SPIKE_LOW_RESET, SPIKE_HIGH_RESET);
    stamp_now = TIME_W'(1000);
    run_traffic(300, 12);
    set_spike_range(16'sh8000, 16'sh7FFF);
    run_traffic(300, 12);
    set_spike_range(16'sh7FFF, 16'sh8000);
    run_traffic(250, 12);
    set_spike_range(CODE_W'($urandom), CODE_W'($urandom));
    run_traffic(300, 12);
    // Run the timestamps through the top of their range.
    spike_lo = CODE_W'($urandom_range(0, 1000));
    set_spike_range(spike_lo, spike_lo + 16'sd2);
    stamp_now = 31'h7FFF_F000;
    run_traffic(300, 12);
  endtask

  task automatic test_back_to_back();
    set_spike_range(-16'sd100, 16'sd100);
    idling_on = 1'b0;
    run_traffic(250, 12);
  endtask

  always begin
    @(posedge clk);
    if (idling_on && $urandom_range(0, 9) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 19)) @(posedge clk);
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 39) == 0) begin
      repeat ($urandom_range(20, 120)) @(posedge clk);
    end
  end

  always @(posedge clk) begin : check_counts
    logic [COUNT_W-1:0] want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_counts.size() == 0) begin
        report_error($sformatf("spike_count %0d with no query pending", spike_count));
      end else begin
        want = expected_counts.pop_front();
        if (spike_count !== want)
          report_error($sformatf("spike_count: expected %0d, got %0d", want, spike_count));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("windowed_event_code_counter_tb: done, errors");
    $finish;
  end

  initial begin
    foreach (ring_times[i]) begin
      ring_times[i] = '0;
      ring_codes[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_empty_ring();
    test_range_registers();
    test_code_extremes();
    test_walk_stops();
    test_mixed_traffic();
    test_back_to_back();
    wait_idle();
    if (error_count == 0 && expected_counts.size() == 0) begin
      $display("windowed_event_code_counter_tb: done, clean");
    end else begin
      $display("windowed_event_code_counter_tb: done, errors");
    end
    $finish;
  end

endmodule
